/* src/nfr_pkg.sv */
package nfr_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SYNC = 2'd1,
    PH_DATA = 2'd2,
    PH_GAP  = 2'd3
  } phase_e;

  localparam int unsigned TickW    = 20;
  localparam int unsigned PeriodW  = 16;
  localparam logic [15:0] PeriodRst = 16'd16;
  localparam logic [2:0]  BitFirst  = 3'd7;
  localparam logic [2:0]  BitLast   = 3'd0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_length;
    logic       last_byte;
    logic       timed_out;
  } result_t;

endpackage

/* src/nfr_sampler.sv */
module nfr_sampler import nfr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [PeriodW-1:0] cfg_data_i,
  input  logic               sample_valid_i,
  input  logic               line_level_i,
  output logic               res_valid_o,
  output result_t            res_o
);

  logic [PeriodW-1:0] period_q;
  phase_e             phase_q, phase_d;
  logic [TickW-1:0]   cnt_q, cnt_d;
  logic [2:0]         idx_q, idx_d;
  logic [7:0]         shift_q, shift_d;
  logic [7:0]         len_q, len_d;
  logic [7:0]         rx_q, rx_d;
  logic               await_q, await_d;

  logic [TickW-1:0]   cnt_inc;
  logic [TickW-1:0]   sync_lim;
  logic [TickW-1:0]   period_ext;
  logic [TickW-1:0]   idle_lim;
  logic [7:0]         rx_inc;
  logic [7:0]         bit_mask;

  assign cnt_inc    = (cnt_q == {TickW{1'b1}}) ? cnt_q : cnt_q + TickW'(1);
  assign period_ext = TickW'(period_q);
  assign sync_lim   = period_ext + TickW'(period_q >> 1);
  assign idle_lim   = (period_ext << 3) + (period_ext << 1);
  assign rx_inc     = rx_q + 8'd1;
  assign bit_mask   = {7'd0, ~line_level_i} << idx_q;

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    shift_d     = shift_q;
    len_d       = len_q;
    rx_d        = rx_q;
    await_d     = await_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (sample_valid_i) begin
      case (phase_q)
        PH_IDLE: begin
          if (line_level_i) begin
            phase_d = PH_SYNC;
            cnt_d   = '0;
          end
        end
        PH_SYNC, PH_DATA: begin
          cnt_d = cnt_inc;
          if ((phase_q == PH_SYNC && cnt_inc >= sync_lim) ||
              (phase_q == PH_DATA && cnt_inc >= period_ext)) begin
            shift_d = shift_q | bit_mask;
            cnt_d   = '0;
            if (idx_q == BitLast) begin
              phase_d = PH_GAP;
            end else begin
              idx_d   = idx_q - 3'd1;
              phase_d = PH_DATA;
            end
          end
        end
        PH_GAP: begin
          if (idx_q == BitLast) begin
            cnt_d = cnt_inc;
            if (cnt_inc >= period_ext) begin
              shift_d           = '0;
              idx_d             = BitFirst;
              cnt_d             = '0;
              res_valid_o       = 1'b1;
              res_o.data_byte   = shift_q;
              if (await_q) begin
                await_d         = 1'b0;
                len_d           = shift_q;
                res_o.is_length = 1'b1;
                if (shift_q == 8'd0) begin
                  res_o.last_byte = 1'b1;
                  phase_d         = PH_IDLE;
                  len_d           = '0;
                  rx_d            = '0;
                  await_d         = 1'b1;
                end
              end else begin
                rx_d = rx_inc;
                if (rx_inc >= len_q) begin
                  res_o.last_byte = 1'b1;
                  phase_d         = PH_IDLE;
                  len_d           = '0;
                  rx_d            = '0;
                  await_d         = 1'b1;
                end
              end
            end
          end else if (line_level_i) begin
            phase_d = PH_SYNC;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_inc;
            if (cnt_inc > idle_lim) begin
              res_valid_o     = 1'b1;
              res_o.timed_out = 1'b1;
              phase_d         = PH_IDLE;
              cnt_d           = '0;
              idx_d           = BitFirst;
              shift_d         = '0;
              len_d           = '0;
              rx_d            = '0;
              await_d         = 1'b1;
            end
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodRst;
      phase_q  <= PH_IDLE;
      cnt_q    <= '0;
      idx_q    <= BitFirst;
      shift_q  <= '0;
      len_q    <= '0;
      rx_q     <= '0;
      await_q  <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_data_i;
      end
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
      len_q   <= len_d;
      rx_q    <= rx_d;
      await_q <= await_d;
    end
  end

endmodule

/* src/nfr_fifo.sv */
module nfr_fifo import nfr_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  result_t wdata_i,
  output logic    full_o,
  output logic    empty_o,
  input  logic    rd_i,
  output result_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

/* src/nrz_frame_receiver.sv */
// Serial frame receiver for a low-idle, inverted NRZ line.
// Input queue: drive one line sample on line_level_i with push; a sample
// transfers when push is high and full is low. Full is high only while
// the result queue has no free entry, so a stalled reader stops sampling.
// Result queue: while empty is low the oldest result sits on data_byte_o,
// is_length_o, last_byte_o and timed_out_o; it transfers on pop.
// Each sample is decoded in the cycle it transfers; a result it causes
// enters the result queue and is on the result ports in the next cycle
// if the queue was empty. While full is low one sample per cycle is taken;
// the Depth-entry queue sets how long a reader may stall before full rises.
// cfg_we_i/cfg_data_i write the bit period in ticks; write only while the
// line is idle.
// Reset clears the sampler to wait for a start bit with the next byte
// taken as a length, empties the result queue and sets the bit period
// to 16.
module nrz_frame_receiver import nfr_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [PeriodW-1:0] cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic               line_level_i,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         data_byte_o,
  output logic               is_length_o,
  output logic               last_byte_o,
  output logic               timed_out_o
);

  logic    sample_valid;
  logic    res_valid;
  result_t res;
  result_t head;

  assign sample_valid = push && !full;

  nfr_sampler u_sampler (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_data_i,
    .sample_valid_i (sample_valid),
    .line_level_i,
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  nfr_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .wr_i    (res_valid),
    .wdata_i (res),
    .full_o  (full),
    .empty_o (empty),
    .rd_i    (pop),
    .rdata_o (head)
  );

  assign data_byte_o = head.data_byte;
  assign is_length_o = head.is_length;
  assign last_byte_o = head.last_byte;
  assign timed_out_o = head.timed_out;

endmodule
